// ===== src/rms_audio_gain_leveler_defines.svh =====
// assertion macros for the gain leveler
`ifndef RMS_AUDIO_GAIN_LEVELER_DEFINES_SVH
`define RMS_AUDIO_GAIN_LEVELER_DEFINES_SVH
// implication checked on every clock outside reset
`define RAGL_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// implication whose consequent is checked in the following cycle
`define RAGL_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== src/ragl_pkg.sv =====
// package with shared types and constants for the gain leveler
`timescale 1ns / 1ps
package ragl_pkg;
  localparam logic signed [15:0] RESET_LEVEL = -16'sd15360;
  localparam logic [16:0] UNITY_GAIN = 17'd65536;
  localparam logic [33:0] DB_PER_LOG2_Q24 = 34'd50504453;
  localparam logic [2:0] REG_ENABLE = 3'd0;
  localparam logic [2:0] REG_DESIRED = 3'd1;
  localparam logic [2:0] REG_MIN_DETECT = 3'd2;
  localparam logic [2:0] REG_INTERVAL = 3'd3;
  localparam logic [2:0] REG_STEP = 3'd4;

  // frame end job handed from front to back
  typedef struct packed {
    logic [63:0] sum;
    logic [12:0] count;
    logic        upd;
  } frame_job_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOG_SUM, ST_LOG_CNT, ST_LOG_GAIN, ST_DB_LEVEL, ST_DB_VOL,
    ST_WIN_RD, ST_DIV, ST_UPDATE, ST_OUT
  } back_state_t;

  typedef enum logic [1:0] {
    LG_IDLE, LG_NORM, LG_SQ, LG_DONE
  } log_state_t;
endpackage

// ===== src/ragl_ram.sv =====
// generic single port ram with registered read
`timescale 1ns / 1ps
module ragl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 60
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== src/ragl_log2.sv =====
// iterative log2 unit, q.16 result, one squaring per cycle
`timescale 1ns / 1ps
module ragl_log2 (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] x,
  output logic        done,
  output logic [22:0] result
);
  import ragl_pkg::*;
  log_state_t st_r, st_nxt;
  logic [63:0] x_r, x_nxt;
  logic [5:0]  k_r, k_nxt;
  logic [32:0] m_r, m_nxt;
  logic [22:0] res_r, res_nxt;
  logic [4:0]  i_r, i_nxt;
  logic [65:0] sq;
  logic [34:0] sq_sh;

  assign sq = m_r * m_r;
  assign sq_sh = sq[65:31];
  assign done = (st_r == LG_DONE);
  assign result = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= LG_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    x_r <= x_nxt;
    k_r <= k_nxt;
    m_r <= m_nxt;
    res_r <= res_nxt;
    i_r <= i_nxt;
  end

  always_comb begin
    st_nxt = st_r;
    x_nxt = x_r;
    k_nxt = k_r;
    m_nxt = m_r;
    res_nxt = res_r;
    i_nxt = i_r;
    unique case (st_r)
      LG_IDLE, LG_DONE: begin
        st_nxt = LG_IDLE;
        if (start) begin
          x_nxt = x;
          k_nxt = 6'd63;
          st_nxt = LG_NORM;
        end
      end
      LG_NORM: begin
        // shift left until top bit set, one position per cycle
        if (x_r[63] || k_r == 6'd0) begin
          m_nxt = {1'b0, x_r[63:32]};
          res_nxt = {1'b0, k_r, 16'd0};
          i_nxt = 5'd15;
          st_nxt = LG_SQ;
        end else begin
          x_nxt = {x_r[62:0], 1'b0};
          k_nxt = k_r - 6'd1;
        end
      end
      LG_SQ: begin
        if (sq_sh[34:32] != 3'd0) begin
          m_nxt = sq_sh[33:1];
          res_nxt = res_r | (23'd1 << i_r[3:0]);
        end else begin
          m_nxt = sq_sh[32:0];
        end
        if (i_r == 5'd0) begin
          st_nxt = LG_DONE;
        end
        i_nxt = i_r - 5'd1;
      end
      default: st_nxt = LG_IDLE;
    endcase
  end
endmodule

// ===== src/ragl_front.sv =====
// front end: square accumulation, tick counting, frame classification
`timescale 1ns / 1ps
module ragl_front #(
  parameter int MAX_FRAME_SAMPLES = 1024,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          operation,
  input  logic [SAMPLE_BITS-1:0]        sample,
  input  logic                          last_in_frame,
  input  logic                          muted,
  input  logic                          enable,
  input  logic [15:0]                   interval,
  output logic                          job_valid,
  input  logic                          job_ready,
  output ragl_pkg::frame_job_t          job
);
  import ragl_pkg::*;
  localparam int CW = $clog2(MAX_FRAME_SAMPLES + 1);
  logic [63:0] sum_r, sum_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [15:0] tick_r, tick_nxt;
  logic jv_r, jv_nxt;
  frame_job_t job_r, job_nxt;
  logic [SAMPLE_BITS-1:0] mag;
  logic [63:0] sq, add;
  logic [64:0] wide;
  logic [CW-1:0] cnt_inc;
  logic acc, ends, upd;

  assign in_ready = !jv_r;
  assign acc = in_valid && in_ready;
  assign mag = sample[SAMPLE_BITS-1] ? (~sample + 1'b1) : sample;
  assign sq = 64'(mag) * 64'(mag);
  assign wide = {1'b0, sum_r} + {1'b0, sq};
  assign add = wide[64] ? '1 : wide[63:0];
  assign cnt_inc = cnt_r + 1'b1;
  assign ends = last_in_frame || (cnt_inc >= CW'(MAX_FRAME_SAMPLES));
  assign upd = (tick_r >= interval);
  assign job_valid = jv_r;
  assign job = job_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      cnt_r <= '0;
      tick_r <= '0;
      jv_r <= 1'b0;
    end else begin
      sum_r <= sum_nxt;
      cnt_r <= cnt_nxt;
      tick_r <= tick_nxt;
      jv_r <= jv_nxt;
    end
    job_r <= job_nxt;
  end

  always_comb begin
    sum_nxt = sum_r;
    cnt_nxt = cnt_r;
    tick_nxt = tick_r;
    jv_nxt = jv_r && !job_ready;
    job_nxt = job_r;
    if (acc) begin
      if (operation) begin
        if (tick_r != 16'hFFFF) begin
          tick_nxt = tick_r + 16'd1;
        end
      end else if (ends) begin
        sum_nxt = '0;
        cnt_nxt = '0;
        if (enable && !muted) begin
          jv_nxt = 1'b1;
          job_nxt.sum = add;
          job_nxt.count = 13'(cnt_inc);
          job_nxt.upd = upd;
          // interval decided at frame end, later ticks count afresh
          if (upd) begin
            tick_nxt = 16'd0;
          end
        end
      end else begin
        sum_nxt = add;
        cnt_nxt = cnt_inc;
      end
    end
  end

  `include "rms_audio_gain_leveler_defines.svh"
  `RAGL_ASSERT_NXT(a_job_hold, jv_r && !job_ready, jv_r && $stable(job_r))
  `RAGL_ASSERT_IMP(a_no_accept_busy, jv_r, !in_ready)
  `RAGL_ASSERT_IMP(a_cnt_range, 1'b1, cnt_r < CW'(MAX_FRAME_SAMPLES))
endmodule

// ===== src/ragl_back.sv =====
// back end: level, window average, target and volume update
`timescale 1ns / 1ps
module ragl_back #(
  parameter int WINDOW_DEPTH = 60,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 job_valid,
  output logic                 job_ready,
  input  ragl_pkg::frame_job_t job,
  input  logic signed [15:0]   desired_db,
  input  logic signed [15:0]   min_detect_db,
  input  logic [16:0]          step,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [16:0]          out_volume,
  output logic signed [15:0]   out_level,
  output logic signed [15:0]   out_target
);
  import ragl_pkg::*;
  localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int VW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH + 1) : 1;
  localparam int SW = 17 + VW;
  localparam logic signed [30:0] OFS_LVL = 31'(2 * (SAMPLE_BITS - 1) + 32) <<< 16;
  localparam logic signed [30:0] OFS_VOL = 31'sd32 <<< 16;
  // ceil(2^31 / depth), exact floor for every window sum magnitude
  localparam longint unsigned RECIP_FULL =
    ((64'd1 << 31) + 64'(WINDOW_DEPTH) - 64'd1) / 64'(WINDOW_DEPTH);
  localparam logic [31:0] RECIP = 32'(RECIP_FULL);

  back_state_t st_r, st_nxt;
  frame_job_t job_r, job_nxt;
  logic [16:0] gain_r, gain_nxt;
  logic signed [15:0] tgt_r, tgt_nxt, lvl_r, lvl_nxt, vdb_r, vdb_nxt, cand_r, cand_nxt;
  logic signed [30:0] acc_r, acc_nxt;
  logic signed [SW-1:0] wsum_r, wsum_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt;
  logic [WINDOW_DEPTH-1:0] vld_r, vld_nxt;
  logic [SW-1:0] q_r, q_nxt;
  logic ov_r, ov_nxt;
  logic lstart;
  logic [63:0] lx;
  logic ldone;
  logic [22:0] lres;
  logic we;
  logic [15:0] rdata, old;
  logic signed [63:0] prod;
  logic signed [31:0] dbq;
  logic signed [15:0] dbsat;
  logic [SW+31:0] qprod;
  logic signed [SW+1:0] avg, tdiff;
  logic signed [18:0] gnew;

  ragl_log2 u_log (.clk, .rst_n, .start(lstart), .x(lx), .done(ldone), .result(lres));
  ragl_ram #(.WIDTH(16), .DEPTH(WINDOW_DEPTH)) u_win (
    .clk, .we, .addr(ptr_r), .wdata(lvl_r), .rdata(rdata));

  // q.16 log to q8.8 db, round half up toward positive, saturate
  assign prod = 64'(acc_r) * $signed({30'd0, DB_PER_LOG2_Q24}) + 64'sd2147483648;
  assign dbq = 32'(prod >>> 32);
  assign dbsat = (dbq > 32'sd32767) ? 16'sh7FFF : (dbq < -32'sd32768) ? -16'sh8000 : dbq[15:0];
  assign old = vld_r[ptr_r] ? rdata : RESET_LEVEL;
  // window average by reciprocal multiply, negative sums rounded toward minus infinity
  assign qprod = (SW+32)'(q_r) * (SW+32)'(RECIP);
  assign avg = ov_r ? -$signed({2'b00, q_r}) : $signed({2'b00, q_r});
  assign tdiff = (SW+2)'(desired_db) - avg;
  assign job_ready = (st_r == ST_IDLE);
  assign out_valid = (st_r == ST_OUT);
  assign out_volume = gain_r;
  assign out_level = lvl_r;
  assign out_target = tgt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      gain_r <= UNITY_GAIN;
      tgt_r <= '0;
      wsum_r <= SW'(WINDOW_DEPTH) * SW'(RESET_LEVEL);
      ptr_r <= '0;
      vld_r <= '0;
    end else begin
      st_r <= st_nxt;
      gain_r <= gain_nxt;
      tgt_r <= tgt_nxt;
      wsum_r <= wsum_nxt;
      ptr_r <= ptr_nxt;
      vld_r <= vld_nxt;
    end
    job_r <= job_nxt;
    lvl_r <= lvl_nxt;
    vdb_r <= vdb_nxt;
    cand_r <= cand_nxt;
    acc_r <= acc_nxt;
    q_r <= q_nxt;
    ov_r <= ov_nxt;
  end

  always_comb begin
    st_nxt = st_r;
    job_nxt = job_r;
    gain_nxt = gain_r;
    tgt_nxt = tgt_r;
    lvl_nxt = lvl_r;
    vdb_nxt = vdb_r;
    cand_nxt = cand_r;
    acc_nxt = acc_r;
    wsum_nxt = wsum_r;
    q_nxt = q_r;
    ov_nxt = ov_r;
    ptr_nxt = ptr_r;
    vld_nxt = vld_r;
    lstart = 1'b0;
    lx = job_r.sum;
    we = 1'b0;
    gnew = '0;
    unique case (st_r)
      ST_IDLE: begin
        if (job_valid) begin
          job_nxt = job;
          lx = job.sum;
          lstart = 1'b1;
          st_nxt = ST_LOG_SUM;
        end
      end
      ST_LOG_SUM: begin
        if (ldone) begin
          acc_nxt = 31'(lres) - OFS_LVL;
          lx = 64'(job_r.count);
          lstart = 1'b1;
          st_nxt = ST_LOG_CNT;
        end
      end
      ST_LOG_CNT: begin
        if (ldone) begin
          acc_nxt = acc_r - 31'(lres);
          lx = 64'(gain_r);
          lstart = 1'b1;
          st_nxt = ST_LOG_GAIN;
        end
      end
      ST_LOG_GAIN: begin
        if (ldone) begin
          acc_nxt = acc_r + 31'({lres, 1'b0});
          st_nxt = ST_DB_LEVEL;
        end
      end
      ST_DB_LEVEL: begin
        lvl_nxt = (job_r.sum == 64'd0 || gain_r == 17'd0) ? -16'sh8000 : dbsat;
        // gain log still held by the log unit
        acc_nxt = 31'({lres, 1'b0}) - OFS_VOL;
        st_nxt = ST_DB_VOL;
      end
      ST_DB_VOL: begin
        vdb_nxt = dbsat;
        ov_nxt = wsum_r[SW-1];
        q_nxt = wsum_r[SW-1] ? SW'(-wsum_r) + SW'(WINDOW_DEPTH - 1) : SW'(wsum_r);
        st_nxt = ST_DIV;
      end
      ST_DIV: begin
        q_nxt = qprod[SW+30:31];
        st_nxt = ST_WIN_RD;
      end
      ST_WIN_RD: begin
        cand_nxt = (tdiff > 32767) ? 16'sh7FFF : (tdiff < -32768) ? -16'sh8000 : tdiff[15:0];
        st_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (job_r.upd) begin
          tgt_nxt = cand_r;
          if (lvl_r > min_detect_db) begin
            we = 1'b1;
            vld_nxt[ptr_r] = 1'b1;
            wsum_nxt = wsum_r + SW'(lvl_r) - SW'($signed(old));
            ptr_nxt = (32'(ptr_r) + 1 >= WINDOW_DEPTH) ? '0 : ptr_r + 1'b1;
          end
          if (gain_r == 17'd0 || vdb_r < cand_r) gnew = 19'(gain_r) + 19'(step);
          else if (vdb_r > cand_r) gnew = 19'(gain_r) - 19'(step);
          else gnew = 19'(gain_r);
        end else begin
          if (gain_r == 17'd0 || vdb_r < tgt_r) gnew = 19'(gain_r) + 19'(step);
          else if (vdb_r > tgt_r) gnew = 19'(gain_r) - 19'(step);
          else gnew = 19'(gain_r);
        end
        gain_nxt = (gnew < 0) ? 17'd0 : (gnew > 19'sd65536) ? UNITY_GAIN : gnew[16:0];
        st_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready) st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  `include "rms_audio_gain_leveler_defines.svh"
  `RAGL_ASSERT_IMP(a_gain_range, 1'b1, gain_r <= UNITY_GAIN)
  `RAGL_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(gain_r))
  `RAGL_ASSERT_IMP(a_take_idle, job_valid && job_ready, st_r == ST_IDLE)
endmodule

// ===== src/rms_audio_gain_leveler.sv =====
// top level of the rms gain leveler
// channel | dir | tdata (low to high)                  | tuser / tlast
// in      | in  | sample                               | operation, muted / last_in_frame
// out     | out | volume[16:0], frame_level_db, target | -
// cfg     | in  | apb registers at 4*i                 | -
// samples and ticks are taken back to back in the front part
// the back processes a frame end mainly in the three log2 runs
// (one normalizing shift per cycle plus 16 squarings each); the front stalls only
// while a frame end waits for the back, the back waits while a result is held
// rst_n is synchronous and active low; the window resets to -60 db through valid bits
`timescale 1ns / 1ps
module rms_audio_gain_leveler #(
  parameter int WINDOW_DEPTH = 60,
  parameter int MAX_FRAME_SAMPLES = 1024,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [SAMPLE_BITS-1:0] in_tdata,   // sample
  input  logic                   in_tlast,   // last_in_frame
  input  logic [1:0]             in_tuser,   // operation, muted
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [55:0]            out_tdata,  // volume, frame_level_db, target_db, pad
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [4:0]             cfg_paddr,
  input  logic [31:0]            cfg_pwdata,
  output logic [31:0]            cfg_prdata,
  output logic                   cfg_pready
);
  import ragl_pkg::*;
  logic en_r;
  logic signed [15:0] des_r, mind_r;
  logic [15:0] intv_r;
  logic [16:0] step_r, vol;
  logic signed [15:0] lvl, tgt;
  logic jv, jr, wr;
  frame_job_t job;
  logic [2:0] ridx;

  assign cfg_pready = 1'b1;
  assign ridx = cfg_paddr[4:2];
  assign wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r <= 1'b0;
      des_r <= RESET_LEVEL;
      mind_r <= -16'sd14336;
      intv_r <= 16'd10;
      step_r <= 17'd655;
    end else if (wr) begin
      unique case (ridx)
        REG_ENABLE: en_r <= cfg_pwdata[0];
        REG_DESIRED: des_r <= cfg_pwdata[15:0];
        REG_MIN_DETECT: mind_r <= cfg_pwdata[15:0];
        REG_INTERVAL: intv_r <= cfg_pwdata[15:0];
        REG_STEP: step_r <= cfg_pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_ENABLE: cfg_prdata = {31'd0, en_r};
      REG_DESIRED: cfg_prdata = {16'd0, des_r};
      REG_MIN_DETECT: cfg_prdata = {16'd0, mind_r};
      REG_INTERVAL: cfg_prdata = {16'd0, intv_r};
      REG_STEP: cfg_prdata = {15'd0, step_r};
      default: cfg_prdata = '0;
    endcase
  end

  ragl_front #(.MAX_FRAME_SAMPLES(MAX_FRAME_SAMPLES), .SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready), .operation(in_tuser[0]),
    .sample(in_tdata), .last_in_frame(in_tlast), .muted(in_tuser[1]), .enable(en_r),
    .interval(intv_r), .job_valid(jv), .job_ready(jr), .job(job));

  ragl_back #(.WINDOW_DEPTH(WINDOW_DEPTH), .SAMPLE_BITS(SAMPLE_BITS)) u_back (
    .clk, .rst_n, .job_valid(jv), .job_ready(jr), .job(job), .desired_db(des_r),
    .min_detect_db(mind_r), .step(step_r),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .out_volume(vol), .out_level(lvl), .out_target(tgt));

  assign out_tdata = {7'd0, tgt, lvl, vol};
endmodule

// ===== sim/rms_audio_gain_leveler_tb.sv =====
// self-checking testbench for the rms gain leveler: random frames and ticks against a predictor
`timescale 1ns / 1ps
module rms_audio_gain_leveler_tb;
  import ragl_pkg::*;

  localparam int WIN_DEPTH = 60;
  localparam int MAX_FRAME = 1024;
  localparam int SETTLE_CYCLES = 400;
  localparam int STALL_LIMIT = 50000;

  typedef enum logic {OP_SAMPLE = 1'b0, OP_TICK = 1'b1} op_t;

  typedef struct {
    op_t op;
    logic [23:0] sample;
    logic last;
    logic muted;
  } audio_item_t;

  typedef struct {
    logic [16:0] volume;
    logic signed [15:0] level;
    logic signed [15:0] target;
  } gain_update_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [23:0] in_tdata;    // sample
  logic in_tlast;           // last_in_frame
  logic [1:0] in_tuser;     // operation, muted
  logic out_tvalid;
  logic out_tready;
  logic [55:0] out_tdata;   // volume, frame_level_db, target_db, pad
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [4:0] cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  rms_audio_gain_leveler u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tlast(in_tlast), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  audio_item_t item_q[$];
  gain_update_t update_q[$];
  int send_idle_pct;
  int recv_stall_pct;
  int hold_off;
  int err_count;
  int stall_count;

  // register copies
  logic en_r;
  int desired_r;
  int min_detect_r;
  int interval_r;
  int step_r;

  // leveler state copies
  logic [63:0] sq_acc;
  int frame_len;
  int level_win[WIN_DEPTH];
  longint win_sum;
  int win_ptr;
  int tick_cnt;
  int latched_target;
  int gain_q16;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint log2_q16(logic [63:0] x);
    int k;
    logic [63:0] m;
    logic [31:0] r;
    k = 63;
    while (k > 0 && !x[k]) k--;
    m = (x << (63 - k)) >> 32;
    r = k << 16;
    for (int i = 15; i >= 0; i--) begin
      m = (m * m) >> 31;
      if (m >= 64'h1_0000_0000) begin
        m = m >> 1;
        r[i] = 1'b1;
      end
    end
    return longint'(r);
  endfunction

  function automatic int sat16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return int'(v);
  endfunction

  function automatic int log2_to_db(longint l);
    longint q;
    longint r;
    q = l * longint'(DB_PER_LOG2_Q24) + 64'sd2147483648;
    if (q >= 0) r = q >>> 32;
    else r = -(((-q) + 64'sd4294967295) >>> 32);
    return sat16(r);
  endfunction

  task automatic leveler_reset();
    en_r = 1'b0;
    desired_r = -15360;
    min_detect_r = -14336;
    interval_r = 10;
    step_r = 655;
    sq_acc = '0;
    frame_len = 0;
    foreach (level_win[i]) level_win[i] = RESET_LEVEL;
    win_sum = WIN_DEPTH * longint'(RESET_LEVEL);
    win_ptr = 0;
    tick_cnt = 0;
    latched_target = 0;
    gain_q16 = UNITY_GAIN;
  endtask

  task automatic predict_gain(audio_item_t it);
    logic [63:0] mag;
    logic [63:0] sq;
    int n;
    int level;
    int target;
    int vol_db;
    longint avg;
    longint g;
    gain_update_t u;
    if (it.op == OP_TICK) begin
      if (tick_cnt < 65535) tick_cnt++;
      return;
    end
    mag = it.sample[23] ? (64'd1 << 24) - {40'd0, it.sample} : {40'd0, it.sample};
    sq = mag * mag;
    sq_acc = (sq_acc > ~sq) ? '1 : sq_acc + sq;
    frame_len++;
    if (!it.last && frame_len < MAX_FRAME) return;
    n = frame_len;
    if (!en_r || it.muted) begin
      sq_acc = '0;
      frame_len = 0;
      return;
    end
    if (sq_acc == 0 || gain_q16 == 0) level = -32768;
    else level = log2_to_db(log2_q16(sq_acc) - log2_q16(64'(n))
                            + 2 * log2_q16(64'(gain_q16)) - (longint'(78) << 16));
    sq_acc = '0;
    frame_len = 0;
    avg = win_sum / WIN_DEPTH;
    if ((win_sum % WIN_DEPTH) != 0 && win_sum < 0) avg--;
    target = sat16(longint'(desired_r) - avg);
    if (tick_cnt >= interval_r) begin
      tick_cnt = 0;
      if (level > min_detect_r) begin
        win_sum += level - level_win[win_ptr];
        level_win[win_ptr] = level;
        win_ptr = (win_ptr + 1 >= WIN_DEPTH) ? 0 : win_ptr + 1;
      end
      latched_target = target;
    end
    vol_db = (gain_q16 == 0) ? 0
           : log2_to_db(2 * log2_q16(64'(gain_q16)) - (longint'(32) << 16));
    g = gain_q16;
    if (gain_q16 == 0 || vol_db < latched_target) g += step_r;
    else if (vol_db > latched_target) g -= step_r;
    if (g < 0) g = 0;
    if (g > UNITY_GAIN) g = UNITY_GAIN;
    gain_q16 = int'(g);
    u.volume = gain_q16[16:0];
    u.level = level[15:0];
    u.target = latched_target[15:0];
    update_q.push_back(u);
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      in_tlast <= 1'b0;
      in_tuser <= '0;
    end else if (!in_tvalid || in_tready) begin
      if (item_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        audio_item_t it;
        it = item_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= it.sample;
        in_tlast <= it.last;
        in_tuser <= {it.muted, it.op};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver with random stalls and long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor: predict on input transaction, check on output transaction
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        audio_item_t it;
        it.op = op_t'(in_tuser[0]);
        it.muted = in_tuser[1];
        it.sample = in_tdata;
        it.last = in_tlast;
        predict_gain(it);
      end
      if (out_tvalid && out_tready) begin
        gain_update_t e;
        if (update_q.size() == 0) begin
          err_count++;
          if (err_count <= 10) $display("unexpected output transaction %h", out_tdata);
        end else begin
          e = update_q.pop_front();
          if (out_tdata[16:0] !== e.volume || out_tdata[32:17] !== e.level
              || out_tdata[48:33] !== e.target) begin
            err_count++;
            if (err_count <= 10)
              $display("mismatch: exp vol %0d lvl %0d tgt %0d, got vol %0d lvl %0d tgt %0d",
                       e.volume, e.level, e.target, out_tdata[16:0],
                       $signed(out_tdata[32:17]), $signed(out_tdata[48:33]));
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel) begin
      stall_count <= 0;
    end else if (stall_count >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    case (idx)
      REG_ENABLE: en_r = value[0];
      REG_DESIRED: desired_r = $signed(value[15:0]);
      REG_MIN_DETECT: min_detect_r = $signed(value[15:0]);
      REG_INTERVAL: interval_r = value[15:0];
      REG_STEP: step_r = value[16:0];
      default: ;
    endcase
  endtask

  task automatic configure(int desired, int min_det, int interval, int step);
    reg_write(REG_DESIRED, desired);
    reg_write(REG_MIN_DETECT, min_det);
    reg_write(REG_INTERVAL, interval);
    reg_write(REG_STEP, step);
  endtask

  task automatic push_item(op_t op, logic [23:0] s, logic last, logic muted);
    audio_item_t it;
    it.op = op;
    it.sample = s;
    it.last = last;
    it.muted = muted;
    item_q.push_back(it);
  endtask

  function automatic logic [23:0] rand_sample();
    logic signed [23:0] s;
    s = 24'($urandom());
    return s >>> $urandom_range(0, 23);
  endfunction

  task automatic push_frame(int len, logic muted);
    for (int i = 0; i < len; i++)
      push_item(OP_SAMPLE, rand_sample(), i == len - 1, muted && i == len - 1);
  endtask

  task automatic push_random(int count);
    int sent;
    int len;
    int pick;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        repeat ($urandom_range(0, 3)) begin
          push_item(OP_TICK, 24'($urandom()), 1'($urandom()), 1'($urandom()));
          sent++;
        end
        len = $urandom_range(1, 10);
        push_frame(len, $urandom_range(9) == 0);
        sent += len;
      end else if (pick < 90) begin
        push_item(OP_TICK, 24'($urandom()), 1'($urandom()), 1'($urandom()));
        sent++;
      end else begin
        push_item(OP_SAMPLE, 24'($urandom()), 1'b0, 1'($urandom()));
        sent++;
      end
    end
  endtask

  task automatic drain();
    while (item_q.size() > 0 || in_tvalid) @(posedge clk);
    while (update_q.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    in_tuser = '0;
    out_tready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off = 0;
    err_count = 0;
    stall_count = 0;
    leveler_reset();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // disabled frame gives nothing
    push_frame(3, 1'b0);
    drain();
    reg_write(REG_ENABLE, 32'd1);
    // extremes, zero frame, muted frame, ticks, long frame
    push_item(OP_SAMPLE, 24'h7FFFFF, 1'b0, 1'b0);
    push_item(OP_SAMPLE, 24'h800000, 1'b1, 1'b0);
    push_item(OP_SAMPLE, 24'h000000, 1'b1, 1'b0);
    push_item(OP_SAMPLE, 24'h123456, 1'b1, 1'b1);
    repeat (10) push_item(OP_TICK, 24'hFFFFFF, 1'b1, 1'b1);
    push_item(OP_SAMPLE, 24'h000100, 1'b1, 1'b0);
    for (int i = 0; i < MAX_FRAME; i++) push_item(OP_SAMPLE, rand_sample(), 1'b0, 1'b0);
    drain();

    configure(0, -32768, 1, 65536);
    push_random(150);
    drain();

    send_idle_pct = 61;
    configure(-32768, 0, 65535, 1);
    push_random(150);
    drain();

    send_idle_pct = 0;
    recv_stall_pct = 61;
    configure(-5000, -20000, 2, 655);
    hold_off = 3000;
    push_random(150);
    drain();

    send_idle_pct = 11;
    recv_stall_pct = 11;
    configure(-12000, -14336, 3, 3000);
    push_random(150);
    drain();

    send_idle_pct = 0;
    recv_stall_pct = 0;
    reg_write(REG_ENABLE, 32'd0);
    push_random(50);
    drain();
    reg_write(REG_ENABLE, 32'd1);
    configure(-2560, -32768, 1, 20000);
    push_random(110);
    drain();

    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+src
src/ragl_pkg.sv
src/ragl_ram.sv
src/ragl_log2.sv
src/ragl_front.sv
src/ragl_back.sv
src/rms_audio_gain_leveler.sv
sim/rms_audio_gain_leveler_tb.sv
